@@ rtl/wwc_pkg.sv @@
// types and seed constants for the weighted word checksum
package wwc_pkg;

	typedef logic [63:0] word_t;

	localparam word_t SEED_SUM    = 64'hc20f9a8b761b7e4c;
	localparam word_t SEED_WEIGHT = 64'h794e80091e8f2bc7;

	// byte lanes absorbed from one request at most
	localparam logic [3:0] LANES_PER_ITEM = 4'd8;

endpackage

@@ rtl/weighted_word_checksum.sv @@
// Rolling weighted 64-bit checksum: one request per cycle unless stalled, one result per request.
// Each result passes through stages s1 to s4 and the output register after its request is accepted.
// The rate is one request per cycle while req_stall is low. The 64x64 multiply is split
// into three 32x32 partial products with two register stages before the running sum.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the seed sum and weight.
module weighted_word_checksum (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  logic           restart,
	input  wwc_pkg::word_t data_bytes,
	input  logic [3:0]     byte_count,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output wwc_pkg::word_t checksum_value
);
	import wwc_pkg::*;

	// checksum state
	word_t      partial_q;
	logic [2:0] fill_q;
	word_t      weight_q;
	word_t      sum_q;

	// pipeline valids
	logic v_s1, v_s2, v_s3, v_s4;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_out;

	// stage payloads
	logic  restart_s1, fire_s1;
	word_t word_s1, wgt_s1, wnext_s1;
	logic  restart_s2, fire_s2;
	word_t pll_s2, wnext_s2;
	logic [31:0] plh_s2, phl_s2;
	logic  restart_s3, fire_s3;
	word_t prod_s3, wnext_s3;
	word_t wnext_s4;

	// absorb logic
	logic [2:0] f_base;
	word_t      p_base, w_base;
	logic [3:0] cnt;
	word_t      masked;
	word_t      merged;
	logic [3:0] total;
	logic       fire;
	logic [3:0] rem;
	word_t      carry_over;

	// handshake: a stage loads when its successor is empty or moving
	assign ld_out    = v_s4 && (!rsp_valid || !rsp_stall);
	assign ld_s4     = v_s3 && (!v_s4 || ld_out);
	assign ld_s3     = v_s2 && (!v_s3 || ld_s4);
	assign ld_s2     = v_s1 && (!v_s2 || ld_s3);
	assign req_stall = v_s1 && !ld_s2;
	assign ld_s1     = req_valid && !req_stall;

	always_comb begin
		f_base = restart ? 3'd0 : fill_q;
		p_base = restart ? '0 : partial_q;
		w_base = restart ? SEED_WEIGHT : weight_q;
		cnt    = (byte_count > LANES_PER_ITEM) ? LANES_PER_ITEM : byte_count;
		for (int i = 0; i < 8; i++) begin
			masked[8*i +: 8] = (4'(i) < cnt) ? data_bytes[8*i +: 8] : 8'h00;
		end
		merged = p_base | (masked << {f_base, 3'b000});
		total  = {1'b0, f_base} + cnt;
		fire   = total[3];
		// bytes that spill past a completed word start the next one
		rem        = 4'd8 - {1'b0, f_base};
		carry_over = masked >> {rem, 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			fill_q    <= '0;
			weight_q  <= SEED_WEIGHT;
			sum_q     <= SEED_SUM;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (ld_s1) begin
				partial_q <= fire ? carry_over : merged;
				fill_q    <= total[2:0];
				weight_q  <= w_base + word_t'(fire);
			end
			if (ld_s4) begin
				sum_q <= (restart_s3 ? SEED_SUM : sum_q) + (fire_s3 ? prod_s3 : '0);
			end
			v_s1      <= ld_s1 || (v_s1 && !ld_s2);
			v_s2      <= ld_s2 || (v_s2 && !ld_s3);
			v_s3      <= ld_s3 || (v_s3 && !ld_s4);
			v_s4      <= ld_s4 || (v_s4 && !ld_out);
			rsp_valid <= ld_out || (rsp_valid && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			restart_s1 <= restart;
			fire_s1    <= fire;
			word_s1    <= merged;
			wgt_s1     <= w_base;
			wnext_s1   <= w_base + word_t'(fire);
		end
		if (ld_s2) begin
			restart_s2 <= restart_s1;
			fire_s2    <= fire_s1;
			pll_s2     <= word_t'(word_s1[31:0]) * word_t'(wgt_s1[31:0]);
			plh_s2     <= word_s1[31:0] * wgt_s1[63:32];
			phl_s2     <= word_s1[63:32] * wgt_s1[31:0];
			wnext_s2   <= wnext_s1;
		end
		if (ld_s3) begin
			restart_s3 <= restart_s2;
			fire_s3    <= fire_s2;
			prod_s3    <= pll_s2 + {plh_s2 + phl_s2, 32'h0000_0000};
			wnext_s3   <= wnext_s2;
		end
		if (ld_s4) begin
			wnext_s4 <= wnext_s3;
		end
		if (ld_out) begin
			checksum_value <= sum_q + wnext_s4;
		end
	end

endmodule

@@ sim/weighted_word_checksum_tb.sv @@
// testbench for weighted_word_checksum: directed table, random requests, scoreboard on checksum
module weighted_word_checksum_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wwc_pkg::*;

	localparam word_t ONES = 64'hffff_ffff_ffff_ffff;
	localparam word_t SEED_CHK = SEED_SUM + SEED_WEIGHT;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int N_DIRECTED = 18;

	typedef struct packed {
		logic       rst;
		word_t      data;
		logic [3:0] cnt;
		logic       known;
		word_t      sum;
	} dir_row_t;

	// rows with known set carry a checksum that follows straight from the seeds
	localparam dir_row_t DIRECTED_REQS [N_DIRECTED] = '{
		'{1'b0, 64'h0,                  4'd0,  1'b1, SEED_CHK},
		'{1'b1, 64'hdead_beef_0bad_f00d, 4'd0,  1'b1, SEED_CHK},
		'{1'b1, ONES,                   4'd8,  1'b1, SEED_SUM + 64'd1},
		'{1'b1, 64'h0,                  4'd8,  1'b1, SEED_CHK + 64'd1},
		'{1'b1, 64'h0,                  4'd15, 1'b1, SEED_CHK + 64'd1},
		'{1'b1, ONES,                   4'd9,  1'b1, SEED_SUM + 64'd1},
		'{1'b1, ONES,                   4'd7,  1'b1, SEED_CHK},
		'{1'b0, ONES,                   4'd1,  1'b1, SEED_SUM + 64'd1},
		'{1'b0, ONES,                   4'd8,  1'b0, 64'h0},
		'{1'b1, 64'h1122_3344_5566_7788, 4'd3,  1'b0, 64'h0},
		'{1'b0, 64'hffee_ddcc_bbaa_9988, 4'd5,  1'b0, 64'h0},
		'{1'b0, 64'h8000_0000_0000_0000, 4'd8,  1'b0, 64'h0},
		'{1'b0, 64'h0123_4567_89ab_cdef, 4'd0,  1'b0, 64'h0},
		'{1'b0, 64'h0000_0000_0000_00a5, 4'd1,  1'b0, 64'h0},
		'{1'b0, 64'h5a5a_5a5a_5a5a_5a5a, 4'd6,  1'b0, 64'h0},
		'{1'b0, 64'h7fff_ffff_ffff_ff7f, 4'd2,  1'b0, 64'h0},
		'{1'b1, 64'hfedc_ba98_7654_3210, 4'd4,  1'b0, 64'h0},
		'{1'b0, 64'h0f0f_0f0f_f0f0_f0f0, 4'd12, 1'b0, 64'h0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	logic       restart;
	word_t      data_bytes;
	logic [3:0] byte_count;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	word_t      checksum_value;

	// predictor state
	word_t      part_word;
	logic [2:0] part_fill;
	word_t      sum_acc;
	word_t      weight_acc;

	word_t      pending_sums [$];
	logic       rsp_hold = 1'b0;
	int         rsp_stall_pct = 0;
	int         req_idle_pct = 0;
	int         n_errors = 0;
	int         n_reqs = 0;
	int         n_sums = 0;
	int         n_restarts = 0;
	int         n_over_limit = 0;
	int         quiet_cycles = 0;
	event       hold_rsp_ev;

	weighted_word_checksum u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.restart        (restart),
		.data_bytes     (data_bytes),
		.byte_count     (byte_count),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.checksum_value (checksum_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic word_t fold_request(input logic rst, input word_t d, input logic [3:0] cnt);
		int unsigned lanes;
		if (rst) begin
			part_word = '0;
			part_fill = '0;
			sum_acc = SEED_SUM;
			weight_acc = SEED_WEIGHT;
		end
		lanes = (cnt > LANES_PER_ITEM) ? LANES_PER_ITEM : cnt;
		for (int i = 0; i < lanes; i++) begin
			part_word[part_fill*8 +: 8] = d[i*8 +: 8];
			if (part_fill == 3'd7) begin
				sum_acc = sum_acc + part_word * weight_acc;
				weight_acc = weight_acc + 64'd1;
				part_word = '0;
				part_fill = '0;
			end else begin
				part_fill = part_fill + 3'd1;
			end
		end
		return sum_acc + weight_acc;
	endfunction

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("%0t mismatch: %s, checksum %h, expected %h", $realtime, what, got, want);
		n_errors++;
	endtask

	// offer one request, return at the edge where it is taken
	task automatic put_req(input logic r, input word_t d, input logic [3:0] c,
			input logic known, input word_t want);
		word_t sum;
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		restart <= r;
		data_bytes <= d;
		byte_count <= c;
		do @(posedge clk); while (req_stall);
		sum = fold_request(r, d, c);
		pending_sums.push_back(known ? want : sum);
		n_reqs++;
		if (r)
			n_restarts++;
		if (c > LANES_PER_ITEM)
			n_over_limit++;
	endtask

	task automatic random_reqs(input int n);
		word_t d;
		logic [3:0] c;
		logic r;
		repeat (n) begin
			d = {$urandom, $urandom};
			if ($urandom_range(7) == 0)
				d = $urandom_range(1) ? ONES : '0;
			r = ($urandom_range(15) == 0);
			case ($urandom_range(9))
				0: c = 4'($urandom_range(15, 9));
				1: c = 4'd0;
				default: c = 4'($urandom_range(8, 1));
			endcase
			put_req(r, d, c, 1'b0, '0);
		end
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_sums.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin : rsp_side
		word_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_sums.size() == 0) begin
				report_mismatch("result with no request outstanding", checksum_value, '0);
			end else begin
				want = pending_sums.pop_front();
				if (checksum_value !== want)
					report_mismatch("checksum_value", checksum_value, want);
				n_sums++;
			end
		end
		rsp_stall <= arst_n && (rsp_hold || ($urandom_range(99) < rsp_stall_pct));
	end

	// long receiver hold-off so the pipeline fills and backs up
	always begin
		@(hold_rsp_ev);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		restart = 1'b0;
		data_bytes = '0;
		byte_count = '0;
		part_word = '0;
		part_fill = '0;
		sum_acc = SEED_SUM;
		weight_acc = SEED_WEIGHT;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			put_req(DIRECTED_REQS[i].rst, DIRECTED_REQS[i].data, DIRECTED_REQS[i].cnt,
				DIRECTED_REQS[i].known, DIRECTED_REQS[i].sum);
		drain();

		random_reqs(250);

		// sender keeps going while the result side is held off
		-> hold_rsp_ev;
		random_reqs(60);
		drain();

		req_idle_pct = 78;
		random_reqs(250);
		drain();

		req_idle_pct = 0;
		rsp_stall_pct <= 78;
		random_reqs(250);

		req_idle_pct = 32;
		rsp_stall_pct <= 32;
		random_reqs(250);

		drain();
		repeat (10) @(posedge clk);

		$display("run covered %0d requests (%0d restarts, %0d counts above the lane limit)",
			n_reqs, n_restarts, n_over_limit);
		$display("%0d checksums compared, %0d mismatches", n_sums, n_errors);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
rtl/wwc_pkg.sv
rtl/weighted_word_checksum.sv
sim/weighted_word_checksum_tb.sv
